// ----- rtl/ffha_pkg.sv -----
// shared types, constants and the microcode program of the first-fit heap allocator
`default_nettype none

package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 12;
  localparam logic [31:0] HEAP_BASE_RESET = 32'hC000_0000;
  localparam int REQ_W = 13;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_TEST,
    S_EVAL,
    S_SPLIT,
    S_TAKE,
    S_FAIL,
    S_FREE
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NSTART,
    C_FREE,
    C_BOUND,
    C_NFIT
  } cond_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_FAIL,
    RES_ALLOC,
    RES_FREE
  } res_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  rd;
    logic  adv;
    logic  wr_tail;
    logic  wr_head;
    logic  wr_free;
    res_t  res;
  } cw_t;

  function automatic cw_t ucode(step_t step);
    cw_t cw;
    cw = '{cond: C_ALWAYS, target: S_IDLE, rd: 1'b0, adv: 1'b0, wr_tail: 1'b0,
           wr_head: 1'b0, wr_free: 1'b0, res: RES_NONE};
    case (step)
      S_IDLE: begin
        cw.cond   = C_NSTART;
        cw.target = S_IDLE;
      end
      S_DISPATCH: begin
        cw.cond   = C_FREE;
        cw.target = S_FREE;
      end
      S_TEST: begin
        cw.rd     = 1'b1;
        cw.cond   = C_BOUND;
        cw.target = S_FAIL;
      end
      S_EVAL: begin
        cw.adv    = 1'b1;
        cw.cond   = C_NFIT;
        cw.target = S_TEST;
      end
      S_SPLIT: begin
        cw.wr_tail = 1'b1;
        cw.target  = S_TAKE;
      end
      S_TAKE: begin
        cw.wr_head = 1'b1;
        cw.res     = RES_ALLOC;
      end
      S_FAIL: begin
        cw.res = RES_FAIL;
      end
      S_FREE: begin
        cw.wr_free = 1'b1;
        cw.res     = RES_FREE;
      end
      default: begin
        cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ffha_store.sv -----
// header store: block lengths and vacant marks, offset 0 held in reset registers
`default_nettype none

module ffha_store
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int OFF_W = $clog2(HEAP_BYTES)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [OFF_W-1:0] rd_addr,
  output logic      [OFF_W-1:0] rd_len,
  output logic                  rd_vac,
  input  wire logic             we_len,
  input  wire logic             we_vac,
  input  wire logic [OFF_W-1:0] wr_addr,
  input  wire logic [OFF_W-1:0] wr_len,
  input  wire logic             wr_vac
);

  logic [OFF_W-1:0] len_mem [HEAP_BYTES];
  logic             vac_mem [HEAP_BYTES];
  logic [OFF_W-1:0] len0;
  logic             vac0;
  logic [OFF_W-1:0] rd_len_q;
  logic             rd_vac_q;
  logic             hit0;

  always_ff @(posedge clk) begin
    if (we_len) begin
      len_mem[wr_addr] <= wr_len;
    end
    if (we_vac) begin
      vac_mem[wr_addr] <= wr_vac;
    end
    if (rd_en) begin
      rd_len_q <= len_mem[rd_addr];
      rd_vac_q <= vac_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len0 <= OFF_W'(HEAP_BYTES - HEADER_BYTES);
      vac0 <= 1'b1;
      hit0 <= 1'b0;
    end else begin
      if (we_len && wr_addr == '0) begin
        len0 <= wr_len;
      end
      if (we_vac && wr_addr == '0) begin
        vac0 <= wr_vac;
      end
      if (rd_en) begin
        hit0 <= (rd_addr == '0);
      end
    end
  end

  assign rd_len = hit0 ? len0 : rd_len_q;
  assign rd_vac = hit0 ? vac0 : rd_vac_q;

endmodule

`default_nettype wire

// ----- rtl/first_fit_heap_allocator.sv -----
// top level: first-fit heap allocator with block splitting, microcoded walk
`default_nettype none

// A request is taken when start is high and busy is low; its single result
// appears on data_address and ok for one cycle with done high, and the
// receiver cannot stall it. A free runs the dispatch and free steps. An
// allocate runs dispatch, then per block header visited a test step (one
// header store read) and an eval step (the fit test), then split and take
// when it fits or fail when the walk runs off the heap; the registered header
// store read keeps read and test apart. No clearing pass is needed after reset.
// heap_base must be written with heap_base_we while idle; the block does not enforce it.

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             func,
  input  wire logic [REQ_W-1:0] request_bytes,
  input  wire logic [31:0]      release_address,
  output logic                  done,
  output logic [31:0]           data_address,
  output logic                  ok,
  input  wire logic             heap_base_we,
  input  wire logic [31:0]      heap_base_wdata
);

  localparam int OFF_W = $clog2(HEAP_BYTES);
  localparam int AW    = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 2;
  localparam logic [AW-1:0] HDR_A  = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] HEAP_A = AW'(HEAP_BYTES);

  step_t            upc;
  step_t            upc_next;
  cw_t              cw;
  logic             take;
  logic             accept;

  logic [31:0]      heap_base;
  logic             func_q;
  logic [REQ_W-1:0] want_q;
  logic [31:0]      addr_q;
  logic [AW-1:0]    off;

  logic [OFF_W-1:0] cur_len;
  logic             cur_vac;
  logic [AW-1:0]    len_a;
  logic [AW-1:0]    want_a;
  logic [AW-1:0]    tail;
  logic             fit;
  logic             bound;
  logic             split;
  logic [31:0]      rel;
  logic             free_ok;

  logic             we_len;
  logic             we_vac;
  logic [OFF_W-1:0] wr_addr;
  logic [OFF_W-1:0] wr_len;
  logic             wr_vac;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    cw = ucode(upc);
    case (cw.cond)
      C_ALWAYS: take = 1'b1;
      C_NSTART: take = !start;
      C_FREE:   take = (func_q == OP_RELEASE);
      C_BOUND:  take = bound;
      C_NFIT:   take = !fit;
      default:  take = 1'b1;
    endcase
    upc_next = take ? cw.target : step_t'(upc + 3'd1);
  end

  assign busy   = (upc != S_IDLE);
  assign accept = start && !busy;

  // datapath
  assign len_a   = AW'(cur_len);
  assign want_a  = AW'(want_q);
  assign tail    = off + HDR_A + want_a;
  assign fit     = cur_vac && (len_a >= want_a);
  assign bound   = (off + HDR_A) > HEAP_A;
  assign split   = (len_a > want_a + HDR_A) && (tail < HEAP_A);
  assign rel     = addr_q - heap_base;
  assign free_ok = (addr_q != '0) && (rel >= 32'(HEADER_BYTES)) && (rel < 32'(HEAP_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= HEAP_BASE_RESET;
    end else if (heap_base_we) begin
      heap_base <= heap_base_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      want_q <= request_bytes;
      addr_q <= release_address;
      off    <= '0;
    end else if (cw.adv && take) begin
      off <= off + HDR_A + len_a;
    end
  end

  always_comb begin
    we_len  = 1'b0;
    we_vac  = 1'b0;
    wr_addr = off[OFF_W-1:0];
    wr_len  = cur_len;
    wr_vac  = 1'b0;
    if (cw.wr_tail && split) begin
      we_len  = 1'b1;
      we_vac  = 1'b1;
      wr_addr = tail[OFF_W-1:0];
      wr_len  = OFF_W'(len_a - want_a - HDR_A);
      wr_vac  = 1'b1;
    end else if (cw.wr_head) begin
      we_len  = 1'b1;
      we_vac  = 1'b1;
      wr_len  = split ? OFF_W'(want_a) : cur_len;
    end else if (cw.wr_free && free_ok) begin
      we_vac  = 1'b1;
      wr_addr = OFF_W'(rel - 32'(HEADER_BYTES));
      wr_vac  = 1'b1;
    end
  end

  ffha_store #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cw.rd),
    .rd_addr (off[OFF_W-1:0]),
    .rd_len  (cur_len),
    .rd_vac  (cur_vac),
    .we_len  (we_len),
    .we_vac  (we_vac),
    .wr_addr (wr_addr),
    .wr_len  (wr_len),
    .wr_vac  (wr_vac)
  );

  // result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cw.res != RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cw.res)
      RES_ALLOC: begin
        data_address <= heap_base + 32'(off) + 32'(HEADER_BYTES);
        ok           <= 1'b1;
      end
      RES_FREE: begin
        data_address <= '0;
        ok           <= free_ok;
      end
      RES_FAIL: begin
        data_address <= '0;
        ok           <= 1'b0;
      end
      default: begin
        data_address <= data_address;
        ok           <= ok;
      end
    endcase
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while a request is still in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted request did not start the sequencer");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !ok |-> data_address == '0)
    else $error("failed or ignored request returned a nonzero address");

  a_split_fit: assert property (@(posedge clk) disable iff (rst)
    upc == S_SPLIT |-> $past(fit))
    else $error("split step reached without a fitting block");

endmodule

`default_nettype wire

// ----- verif/first_fit_heap_allocator_test.sv -----
// testbench for the first-fit heap allocator: directed and random requests checked by a scoreboard
`timescale 1ns / 1ps

module first_fit_heap_allocator_test;
  import ffha_pkg::*;

  localparam int HEAP = HEAP_BYTES_DEF;
  localparam int HDR = HEADER_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [31:0] address;
    logic        ok;
  } grant_t;

  class heap_tracker;
    bit [12:0]   block_length [HEAP];
    bit          block_vacant [HEAP];
    logic [31:0] heap_base;
    grant_t      expected_grants [$];
    int unsigned live_offsets [$];
    int errors;
    int n_granted, n_refused, n_released, n_ignored;

    function new();
      heap_base = HEAP_BASE_RESET;
      block_length[0] = 13'(HEAP - HDR);
      block_vacant[0] = 1'b1;
    endfunction

    function grant_t predict_alloc(int unsigned want);
      int unsigned off, len, tail;
      off = 0;
      while (off + HDR <= HEAP) begin
        len = block_length[off];
        if (block_vacant[off] && len >= want) begin
          tail = off + HDR + want;
          if (len > want + HDR && tail < HEAP) begin
            block_length[tail] = 13'(len - want - HDR);
            block_vacant[tail] = 1'b1;
            block_length[off] = 13'(want);
          end
          block_vacant[off] = 1'b0;
          live_offsets.push_back(off);
          n_granted++;
          return '{heap_base + 32'(off + HDR), 1'b1};
        end
        off = off + HDR + len;
      end
      n_refused++;
      return '{32'd0, 1'b0};
    endfunction

    function grant_t predict_release(logic [31:0] addr);
      logic [31:0] rel;
      rel = addr - heap_base;
      if (addr == 32'd0 || rel < HDR || rel >= HEAP) begin
        n_ignored++;
        return '{32'd0, 1'b0};
      end
      block_vacant[rel - HDR] = 1'b1;
      n_released++;
      return '{32'd0, 1'b1};
    endfunction

    function void note_request(logic f, logic [12:0] want, logic [31:0] addr);
      if (f == OP_ALLOC) expected_grants.push_back(predict_alloc(want));
      else expected_grants.push_back(predict_release(addr));
    endfunction

    function void check_result(logic [31:0] addr, logic ok_bit);
      grant_t due;
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result data_address %h ok %b", $time, addr, ok_bit);
        errors++;
        return;
      end
      due = expected_grants.pop_front();
      if (addr !== due.address) begin
        $display("%0t: data_address expected %h got %h", $time, due.address, addr);
        errors++;
      end
      if (ok_bit !== due.ok) begin
        $display("%0t: ok expected %b got %b", $time, due.ok, ok_bit);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = 1'b0;
  logic [12:0] request_bytes = '0;
  logic [31:0] release_address = '0;
  logic        heap_base_we = 1'b0;
  logic [31:0] heap_base_wdata = '0;
  logic        busy, done, ok;
  logic [31:0] data_address;

  heap_tracker tracker;
  bit steady = 1'b0;
  int idle_cycles = 0;

  first_fit_heap_allocator i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .request_bytes   (request_bytes),
    .release_address (release_address),
    .done            (done),
    .data_address    (data_address),
    .ok              (ok),
    .heap_base_we    (heap_base_we),
    .heap_base_wdata (heap_base_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_result(data_address, ok);
      if (start && !busy) tracker.note_request(func, request_bytes, release_address);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("first_fit_heap_allocator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue(input logic f, input logic [12:0] want, input logic [31:0] addr);
    start <= 1'b1;
    func <= f;
    request_bytes <= want;
    release_address <= addr;
    do @(posedge clk); while (busy);
    if (!steady && $urandom_range(99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.expected_grants.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    drain();
    heap_base_we <= 1'b1;
    heap_base_wdata <= value;
    @(posedge clk);
    heap_base_we <= 1'b0;
    tracker.heap_base = value;
  endtask

  function automatic logic [12:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 13'($urandom_range(64));
    if (r < 90) return 13'($urandom_range(65, 512));
    if (r < 98) return 13'($urandom_range(513, 4095));
    return 13'(HEAP);
  endfunction

  task automatic random_request();
    int unsigned pick, k, off;
    logic [31:0] b;
    if ($urandom_range(99) == 0) drain();
    pick = $urandom_range(99);
    b = tracker.heap_base;
    if (pick < 55 || tracker.live_offsets.size() == 0) begin
      issue(OP_ALLOC, pick_size(), $urandom);
    end else if (pick < 85) begin
      k = $urandom_range(tracker.live_offsets.size() - 1);
      off = tracker.live_offsets[k];
      tracker.live_offsets.delete(k);
      issue(OP_RELEASE, 13'($urandom), b + 32'(off + HDR));
    end else if (pick < 91) begin
      issue(OP_RELEASE, 13'($urandom), b + 32'($urandom_range(HDR, HEAP - 1)));
    end else if (pick < 94) begin
      issue(OP_RELEASE, 13'($urandom), 32'd0);
    end else begin
      issue(OP_RELEASE, 13'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [31:0] b;
    tracker = new();
    b = HEAP_BASE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(OP_ALLOC, 13'd0, 32'd0);
    issue(OP_ALLOC, 13'd4096, 32'hFFFF_FFFF);
    issue(OP_ALLOC, 13'd100, 32'd0);
    issue(OP_ALLOC, 13'd88, 32'd0);
    issue(OP_RELEASE, 13'd0, 32'd0);
    issue(OP_RELEASE, 13'h1FFF, b + 32'd11);
    issue(OP_RELEASE, 13'd0, b + 32'd4096);
    issue(OP_RELEASE, 13'd0, b - 32'd1);
    issue(OP_RELEASE, 13'd0, b + 32'd4095);
    issue(OP_RELEASE, 13'd0, b + 32'd24);
    issue(OP_RELEASE, 13'd0, b + 32'd24);
    // no split: block is exactly one header larger than the request
    issue(OP_ALLOC, 13'd88, 32'd0);
    issue(OP_RELEASE, 13'd0, b + 32'd12);
    issue(OP_ALLOC, 13'd0, 32'd0);
    issue(OP_ALLOC, 13'd3860, 32'd0);
    issue(OP_ALLOC, 13'd0, 32'd0);
    issue(OP_RELEASE, 13'd0, b + 32'd236);
    issue(OP_ALLOC, 13'd3847, 32'd0);
    issue(OP_ALLOC, 13'd1, 32'd0);
    issue(OP_ALLOC, 13'd4095, 32'd0);
    repeat (200) random_request();

    write_base(32'h0000_0000);
    steady = 1'b1;
    repeat (250) random_request();
    steady = 1'b0;

    // heap straddles address zero
    write_base(32'hFFFF_F800);
    issue(OP_RELEASE, 13'd0, 32'd0);
    issue(OP_RELEASE, 13'd0, 32'hFFFF_F80C);
    repeat (200) random_request();

    write_base(32'hFFFF_FFFF);
    repeat (200) random_request();

    write_base($urandom);
    repeat (200) random_request();

    drain();
    repeat (20) @(posedge clk);
    if (tracker.expected_grants.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.expected_grants.size());
      tracker.errors++;
    end
    $display("covered %0d allocations granted, %0d refused, %0d frees applied, %0d ignored",
             tracker.n_granted, tracker.n_refused, tracker.n_released, tracker.n_ignored);
    $display("across five heap bases, including zero, all ones and a base that wraps");
    if (tracker.errors == 0) begin
      $display("first_fit_heap_allocator test passed");
    end else begin
      $display("first_fit_heap_allocator test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ffha_pkg.sv
rtl/ffha_store.sv
rtl/first_fit_heap_allocator.sv
verif/first_fit_heap_allocator_test.sv
